### rtl/stick_gesture_mode_select_assert.svh
// Assertion macros for the stick gesture mode select block.
// Expects clk and rst in the scope of the user.
`ifndef STICK_GESTURE_MODE_SELECT_ASSERT_SVH
`define STICK_GESTURE_MODE_SELECT_ASSERT_SVH

// same-cycle implication
`define SGMS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SGMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/sgms_pkg.sv
// Types, constants and gesture tables of the stick gesture mode select block.
// No dependencies.
`timescale 1ns / 1ps
package sgms_pkg;

  localparam int NUM_CH       = 4;
  localparam int NUM_GESTURES = 6;
  localparam int READ_GESTURE = 5;

  typedef logic signed [10:0]           stick_t;
  typedef logic [NUM_CH-1:0][10:0]      stick_vec_t;
  typedef logic [4:0]                   key_t;
  typedef logic [2:0]                   mode_t;
  typedef logic [2:0]                   buzz_t;
  typedef logic [9:0]                   thr_t;
  typedef logic [14:0]                  hold_t;
  typedef logic [1:0]                   cfg_idx_t;
  typedef logic [14:0]                  cfg_data_t;
  typedef logic [NUM_GESTURES-1:0]      gest_vec_t;

  typedef struct packed {
    thr_t  threshold;
    hold_t hold_ticks;
  } cfg_t;

  typedef struct packed {
    gest_vec_t match;
    gest_vec_t active;
  } gesture_status_t;

  // register indexes
  localparam cfg_idx_t REG_THRESHOLD = 2'd0;
  localparam cfg_idx_t REG_HOLD      = 2'd1;

  localparam thr_t  THRESHOLD_RESET = 10'd650;
  localparam hold_t HOLD_RESET      = 15'd500;
  localparam hold_t COUNTER_MAX     = '1;

  // key bits
  localparam int KEY_F = 0;
  localparam int KEY_C = 1;
  localparam int KEY_V = 2;
  localparam int KEY_R = 3;
  localparam int KEY_X = 4;

  localparam mode_t MODE_0     = 3'd0;
  localparam mode_t MODE_1     = 3'd1;
  localparam mode_t MODE_2     = 3'd2;
  localparam mode_t MODE_3     = 3'd3;
  localparam mode_t MODE_4     = 3'd4;
  localparam mode_t MODE_RESET = MODE_1;
  localparam mode_t MODE_MAX   = MODE_4;

  localparam buzz_t BUZZ_NONE = 3'd0;
  localparam buzz_t BUZZ_LONG = 3'd5;

  // bit i set: channel i must be above +thr; clear: below -thr
  localparam logic [NUM_CH-1:0] GESTURE_POS [NUM_GESTURES] = '{
    4'b0011, 4'b1011, 4'b0001, 4'b1110, 4'b0100, 4'b1001
  };
  localparam mode_t GESTURE_MODE [NUM_GESTURES] = '{
    MODE_2, MODE_4, MODE_3, MODE_1, MODE_0, MODE_0
  };
  localparam buzz_t GESTURE_BUZZ [NUM_GESTURES] = '{
    3'd2, 3'd4, 3'd3, 3'd1, BUZZ_LONG, BUZZ_NONE
  };

endpackage

### rtl/sgms_if.sv
// Valid/ready channel interfaces: stick input words, result words, config writes.
// Depends on sgms_pkg.
`timescale 1ns / 1ps
interface sgms_in_if;
  logic             valid;
  logic             ready;
  sgms_pkg::stick_t stick_ch0;
  sgms_pkg::stick_t stick_ch1;
  sgms_pkg::stick_t stick_ch2;
  sgms_pkg::stick_t stick_ch3;
  sgms_pkg::key_t   key_flags;

  modport source (output valid, stick_ch0, stick_ch1, stick_ch2, stick_ch3, key_flags,
                  input ready);
  modport sink   (input valid, stick_ch0, stick_ch1, stick_ch2, stick_ch3, key_flags,
                  output ready);
endinterface

interface sgms_out_if;
  logic            valid;
  logic            ready;
  sgms_pkg::mode_t sent_mode;
  sgms_pkg::mode_t final_mode;
  sgms_pkg::buzz_t buzzer_code;

  modport source (output valid, sent_mode, final_mode, buzzer_code, input ready);
  modport sink   (input valid, sent_mode, final_mode, buzzer_code, output ready);
endinterface

interface sgms_cfg_if;
  logic                valid;
  logic                ready;
  sgms_pkg::cfg_idx_t  index;
  sgms_pkg::cfg_data_t data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/sgms_cfg_regs.sv
// Configuration registers: stick threshold and hold limit.
// Depends on sgms_pkg and sgms_cfg_if.
`timescale 1ns / 1ps
module sgms_cfg_regs (
  input  logic           clk,
  input  logic           rst,
  sgms_cfg_if.sink       cfg,
  output sgms_pkg::cfg_t regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.threshold  <= sgms_pkg::THRESHOLD_RESET;
      regs.hold_ticks <= sgms_pkg::HOLD_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == sgms_pkg::REG_THRESHOLD) begin
        regs.threshold <= cfg.data[9:0];
      end else if (cfg.index == sgms_pkg::REG_HOLD) begin
        regs.hold_ticks <= cfg.data;
      end
    end
  end

endmodule

### rtl/sgms_gesture_track.sv
// Gesture match and saturating hold counters, one per gesture.
// Depends on sgms_pkg.
`timescale 1ns / 1ps
module sgms_gesture_track (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      advance,
  input  sgms_pkg::stick_vec_t      sticks,
  input  sgms_pkg::cfg_t            regs,
  output sgms_pkg::gesture_status_t status
);

  sgms_pkg::hold_t   counters      [sgms_pkg::NUM_GESTURES];
  sgms_pkg::hold_t   counters_next [sgms_pkg::NUM_GESTURES];
  logic signed [11:0] thr_pos;
  logic signed [11:0] thr_neg;
  logic [sgms_pkg::NUM_CH-1:0] above;
  logic [sgms_pkg::NUM_CH-1:0] below;

  always_comb begin
    logic signed [11:0] ch_ext;
    thr_pos = $signed({2'b00, regs.threshold});
    thr_neg = -thr_pos;
    for (int i = 0; i < sgms_pkg::NUM_CH; i++) begin
      ch_ext   = $signed({sticks[i][10], sticks[i]});
      above[i] = ch_ext > thr_pos;
      below[i] = ch_ext < thr_neg;
    end
  end

  always_comb begin
    for (int g = 0; g < sgms_pkg::NUM_GESTURES; g++) begin
      status.match[g] = &((above & sgms_pkg::GESTURE_POS[g]) |
                          (below & ~sgms_pkg::GESTURE_POS[g]));
      if (!status.match[g]) begin
        counters_next[g] = '0;
      end else if (counters[g] == sgms_pkg::COUNTER_MAX) begin
        counters_next[g] = counters[g];
      end else begin
        counters_next[g] = counters[g] + 15'd1;
      end
      status.active[g] = counters_next[g] > regs.hold_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < sgms_pkg::NUM_GESTURES; g++) begin
        counters[g] <= '0;
      end
    end else if (advance) begin
      for (int g = 0; g < sgms_pkg::NUM_GESTURES; g++) begin
        counters[g] <= counters_next[g];
      end
    end
  end

endmodule

### rtl/stick_gesture_mode_select.sv
// Stick gesture mode select: an input register followed by a result register.
// Throughput one word per cycle; a stalled result holds the input register.
// Rate set by the single mode/counter update path, one word per clock.
// Reset (synchronous): mode 1, hold counters zero, threshold 650, hold limit 500.
// Depends on sgms_pkg, sgms_if, sgms_cfg_regs, sgms_gesture_track and the assert header.
`timescale 1ns / 1ps
`include "stick_gesture_mode_select_assert.svh"
module stick_gesture_mode_select (
  input  logic       clk,
  input  logic       rst,
  sgms_in_if.sink    in_ch,
  sgms_out_if.source out_ch,
  sgms_cfg_if.sink   cfg
);

  sgms_pkg::cfg_t            regs;
  sgms_pkg::gesture_status_t status;

  logic                 s1_valid;
  sgms_pkg::stick_vec_t s1_sticks;
  sgms_pkg::key_t       s1_keys;
  logic                 advance;

  sgms_pkg::mode_t current_mode;
  sgms_pkg::mode_t current_mode_next;
  sgms_pkg::mode_t sent_next;
  sgms_pkg::buzz_t buzz_next;

  logic            out_valid;
  sgms_pkg::mode_t sent_mode;
  sgms_pkg::mode_t final_mode;
  sgms_pkg::buzz_t buzzer_code;

  sgms_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  sgms_gesture_track u_track (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .sticks  (s1_sticks),
    .regs    (regs),
    .status  (status)
  );

  assign advance      = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready  = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_sticks <= {in_ch.stick_ch3, in_ch.stick_ch2, in_ch.stick_ch1, in_ch.stick_ch0};
      s1_keys   <= in_ch.key_flags;
    end
  end

  always_comb begin
    sgms_pkg::mode_t m;
    m = current_mode;
    if (s1_keys[sgms_pkg::KEY_F]) m = sgms_pkg::MODE_1;
    if (s1_keys[sgms_pkg::KEY_C]) m = sgms_pkg::MODE_3;
    if (s1_keys[sgms_pkg::KEY_V]) m = sgms_pkg::MODE_4;
    if (s1_keys[sgms_pkg::KEY_R]) m = sgms_pkg::MODE_2;
    if (s1_keys[sgms_pkg::KEY_X]) m = sgms_pkg::MODE_0;
    sent_next = m;
    buzz_next = sgms_pkg::BUZZ_NONE;
    for (int g = 0; g < sgms_pkg::NUM_GESTURES; g++) begin
      if (status.active[g]) begin
        if (g == sgms_pkg::READ_GESTURE) begin
          buzz_next = (m != sgms_pkg::MODE_0) ? m : sgms_pkg::BUZZ_LONG;
        end else begin
          m         = sgms_pkg::GESTURE_MODE[g];
          buzz_next = sgms_pkg::GESTURE_BUZZ[g];
        end
      end
    end
    current_mode_next = m;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_mode <= sgms_pkg::MODE_RESET;
      out_valid    <= 1'b0;
    end else begin
      if (advance) begin
        current_mode <= current_mode_next;
        out_valid    <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sent_mode   <= sent_next;
      final_mode  <= current_mode_next;
      buzzer_code <= buzz_next;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.sent_mode   = sent_mode;
  assign out_ch.final_mode  = final_mode;
  assign out_ch.buzzer_code = buzzer_code;

  `SGMS_ASSERT_NOW(a_one_gesture, s1_valid, $onehot0(status.match), "two gestures match at once")
  `SGMS_ASSERT_NOW(a_active_match, s1_valid, ~|(status.active & ~status.match), "active no match")
  `SGMS_ASSERT_NEXT(a_advance_result, advance, out_valid, "result missing after advance")
  `SGMS_ASSERT_NEXT(a_stall_hold, s1_valid && !advance, s1_valid, "stalled word dropped")
  `SGMS_ASSERT_NOW(a_mode_range, 1'b1, current_mode <= sgms_pkg::MODE_MAX, "mode out of range")

endmodule

### tb/testbench.sv
// Self-checking testbench for stick_gesture_mode_select: stick words and config writes
// are checked against an in-bench model of the mode and gesture hold logic.
// Depends on sgms_pkg, the sgms_if interfaces and the block itself.
`timescale 1ns / 1ps
module testbench;
  import sgms_pkg::*;

  localparam int NUM_GEST    = 6;
  localparam int GEST_READ   = 5;
  localparam int CNT_TOP     = 32767;
  localparam int QUIET_LIMIT = 1000;
  localparam int SETTLE      = 4;
  localparam int THR_INIT    = 650;
  localparam int HOLD_INIT   = 500;

  localparam cfg_idx_t REG_UNUSED_LO = 2'd2;
  localparam cfg_idx_t REG_UNUSED_HI = 2'd3;

  localparam buzz_t BEEP_1 = 3'd1;
  localparam buzz_t BEEP_2 = 3'd2;
  localparam buzz_t BEEP_3 = 3'd3;
  localparam buzz_t BEEP_4 = 3'd4;

  // bit i set: channel i above +thr, clear: below -thr; gesture 0 in the low nibble
  localparam logic [NUM_GEST-1:0][3:0] DIR_POS = {
    4'b1001, 4'b0100, 4'b1110, 4'b0001, 4'b1011, 4'b0011
  };
  localparam logic [NUM_GEST-2:0][2:0] ACT_MODE = {MODE_0, MODE_1, MODE_3, MODE_4, MODE_2};
  localparam logic [NUM_GEST-2:0][2:0] ACT_BUZZ = {BUZZ_LONG, BEEP_1, BEEP_3, BEEP_4, BEEP_2};

  typedef enum logic [1:0] {OP_WORD, OP_CFG, OP_DRAIN} op_kind_e;

  typedef struct {
    op_kind_e  kind;
    stick_t    c0;
    stick_t    c1;
    stick_t    c2;
    stick_t    c3;
    key_t      keys;
    cfg_idx_t  idx;
    cfg_data_t data;
    int        gap;
    int        stall_pct;
  } stim_op_t;

  typedef struct packed {
    mode_t sent_mode;
    mode_t final_mode;
    buzz_t buzzer_code;
  } mode_word_t;

  logic clk = 1'b0;
  logic rst;

  sgms_in_if  in_if ();
  sgms_out_if out_if ();
  sgms_cfg_if cfg_if ();

  stick_gesture_mode_select i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg    (cfg_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  stim_op_t   op_q[$];
  mode_word_t modes_due[$];

  // model state
  int    thr_now  = THR_INIT;
  int    hold_now = HOLD_INIT;
  int    hold_cnt [NUM_GEST];
  mode_t mode_now = MODE_1;

  // stimulus planning
  int plan_thr       = THR_INIT;
  int plan_hold      = HOLD_INIT;
  int plan_gap_pct   = 0;
  int plan_stall_pct = 0;

  int gap_left    = 0;
  int settle_left = 0;
  int stall_left  = 0;
  int stall_pct   = 0;
  int quiet       = 0;
  int mismatches  = 0;

  function automatic mode_word_t predict_tick(stick_t c0, stick_t c1, stick_t c2, stick_t c3,
                                              key_t keys);
    int         ch [4];
    bit         holds;
    mode_word_t r;
    ch[0] = c0;
    ch[1] = c1;
    ch[2] = c2;
    ch[3] = c3;
    if (keys[KEY_F]) mode_now = MODE_1;
    if (keys[KEY_C]) mode_now = MODE_3;
    if (keys[KEY_V]) mode_now = MODE_4;
    if (keys[KEY_R]) mode_now = MODE_2;
    if (keys[KEY_X]) mode_now = MODE_0;
    r.sent_mode   = mode_now;
    r.buzzer_code = BUZZ_NONE;
    for (int g = 0; g < NUM_GEST; g++) begin
      holds = 1'b1;
      for (int i = 0; i < 4; i++) begin
        if (DIR_POS[g][i]) holds &= (ch[i] > thr_now);
        else holds &= (ch[i] < -thr_now);
      end
      if (holds) begin
        if (hold_cnt[g] < CNT_TOP) hold_cnt[g]++;
      end else begin
        hold_cnt[g] = 0;
      end
      if (hold_cnt[g] > hold_now) begin
        if (g == GEST_READ) begin
          r.buzzer_code = (mode_now == MODE_0) ? BUZZ_LONG : buzz_t'(mode_now);
        end else begin
          mode_now      = ACT_MODE[g];
          r.buzzer_code = ACT_BUZZ[g];
        end
      end
    end
    r.final_mode = mode_now;
    return r;
  endfunction

  function automatic void apply_write(cfg_idx_t idx, cfg_data_t d);
    case (idx)
      REG_THRESHOLD: thr_now = d[9:0];
      REG_HOLD:      hold_now = d;
      default: ;
    endcase
  endfunction

  task automatic add_word(int c0, int c1, int c2, int c3, int keys);
    stim_op_t op;
    op.kind      = OP_WORD;
    op.c0        = stick_t'(c0);
    op.c1        = stick_t'(c1);
    op.c2        = stick_t'(c2);
    op.c3        = stick_t'(c3);
    op.keys      = key_t'(keys);
    op.idx       = REG_THRESHOLD;
    op.data      = '0;
    op.gap       = ($urandom_range(99) < plan_gap_pct) ? $urandom_range(13, 1) : 0;
    op.stall_pct = plan_stall_pct;
    op_q.push_back(op);
  endtask

  task automatic add_cfg(cfg_idx_t idx, int data);
    stim_op_t op;
    op.kind      = OP_CFG;
    op.c0        = '0;
    op.c1        = '0;
    op.c2        = '0;
    op.c3        = '0;
    op.keys      = '0;
    op.idx       = idx;
    op.data      = cfg_data_t'(data);
    op.gap       = 0;
    op.stall_pct = plan_stall_pct;
    op_q.push_back(op);
    if (idx == REG_THRESHOLD) plan_thr = data;
    if (idx == REG_HOLD) plan_hold = data;
  endtask

  task automatic add_drain();
    stim_op_t op;
    op.kind      = OP_DRAIN;
    op.c0        = '0;
    op.c1        = '0;
    op.c2        = '0;
    op.c3        = '0;
    op.keys      = '0;
    op.idx       = REG_THRESHOLD;
    op.data      = '0;
    op.gap       = 0;
    op.stall_pct = plan_stall_pct;
    op_q.push_back(op);
  endtask

  function automatic int deflect(bit pos, int thr);
    int m;
    if (pos) begin
      if (thr >= 1023) return 1023;
      m = $urandom_range(1023, thr + 1);
      return m;
    end
    m = $urandom_range(1024, thr + 1);
    return -m;
  endfunction

  // bent_ch >= 0: that channel lands inside the dead band
  task automatic add_gesture_tick(int g, int keys, int bent_ch);
    int v [4];
    for (int i = 0; i < 4; i++) begin
      v[i] = deflect(DIR_POS[g][i], plan_thr);
      if (i == bent_ch) v[i] = int'($urandom_range(2 * plan_thr)) - plan_thr;
    end
    add_word(v[0], v[1], v[2], v[3], keys);
  endtask

  function automatic int rand_keys();
    return ($urandom_range(7) == 0) ? $urandom_range(31) : 0;
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(3))
      0: return 0;
      1: return 10;
      2: return 30;
      default: return 60;
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    stim_op_t op;
    bit       word_go;
    bit       cfg_go;
    if (rst) begin
      in_if.valid  <= 1'b0;
      cfg_if.valid <= 1'b0;
    end else if ((!in_if.valid || in_if.ready) && (!cfg_if.valid || cfg_if.ready)) begin
      word_go = 1'b0;
      cfg_go  = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (settle_left > 0) begin
        settle_left--;
      end else if (op_q.size() > 0) begin
        op = op_q[0];
        case (op.kind)
          OP_WORD: begin
            if (op.gap > 0) begin
              gap_left      = op.gap - 1;
              op_q[0].gap   = 0;
            end else begin
              in_if.stick_ch0 <= op.c0;
              in_if.stick_ch1 <= op.c1;
              in_if.stick_ch2 <= op.c2;
              in_if.stick_ch3 <= op.c3;
              in_if.key_flags <= op.keys;
              stall_pct       <= op.stall_pct;
              word_go = 1'b1;
              void'(op_q.pop_front());
            end
          end
          OP_CFG: begin
            cfg_if.index <= op.idx;
            cfg_if.data  <= op.data;
            cfg_go = 1'b1;
            void'(op_q.pop_front());
          end
          default: begin
            if (!in_if.valid && modes_due.size() == 0) begin
              settle_left = SETTLE;
              void'(op_q.pop_front());
            end
          end
        endcase
      end
      in_if.valid  <= word_go;
      cfg_if.valid <= cfg_go;
    end
  end

  // result sink stalls
  always @(posedge clk) begin
    if (rst) begin
      out_if.ready <= 1'b0;
    end else begin
      if (stall_left == 0 && $urandom_range(99) < stall_pct) stall_left = $urandom_range(13, 1);
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    mode_word_t got;
    mode_word_t want;
    if (!rst) begin
      if (cfg_if.valid && cfg_if.ready) apply_write(cfg_if.index, cfg_if.data);
      if (out_if.valid && out_if.ready) begin
        got.sent_mode   = out_if.sent_mode;
        got.final_mode  = out_if.final_mode;
        got.buzzer_code = out_if.buzzer_code;
        if (modes_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result word with none expected: sent %0d final %0d buzz %0d",
                     $time, got.sent_mode, got.final_mode, got.buzzer_code);
        end else begin
          want = modes_due.pop_front();
          if (got.sent_mode !== want.sent_mode || got.final_mode !== want.final_mode ||
              got.buzzer_code !== want.buzzer_code) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: mismatch: want sent %0d final %0d buzz %0d, ",
                        "got sent %0d final %0d buzz %0d"},
                       $time, want.sent_mode, want.final_mode, want.buzzer_code,
                       got.sent_mode, got.final_mode, got.buzzer_code);
          end
        end
      end
      if (in_if.valid && in_if.ready)
        modes_due.push_back(predict_tick(in_if.stick_ch0, in_if.stick_ch1, in_if.stick_ch2,
                                         in_if.stick_ch3, in_if.key_flags));
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= QUIET_LIMIT) begin
          $display("testbench: FAIL");
          $finish;
        end
      end
    end
  end

  initial begin
    int thr;
    int hold;
    int n;
    int g;
    int len;
    int bent_at;
    bit paused;
    rst              = 1'b1;
    in_if.valid      = 1'b0;
    in_if.stick_ch0  = '0;
    in_if.stick_ch1  = '0;
    in_if.stick_ch2  = '0;
    in_if.stick_ch3  = '0;
    in_if.key_flags  = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = REG_THRESHOLD;
    cfg_if.data      = '0;
    out_if.ready     = 1'b0;
    for (int i = 0; i < NUM_GEST; i++) hold_cnt[i] = 0;

    // keys and stick extremes at reset settings
    plan_gap_pct   = 20;
    plan_stall_pct = 20;
    add_word(0, 0, 0, 0, 0);
    for (int k = KEY_F; k <= KEY_X; k++) add_word(0, 0, 0, 0, 1 << k);
    add_word(0, 0, 0, 0, 31);
    add_word(0, 0, 0, 0, (1 << KEY_F) | (1 << KEY_C));
    add_word(0, 0, 0, 0, (1 << KEY_V) | (1 << KEY_R));
    add_word(1023, 1023, 1023, 1023, 0);
    add_word(-1024, -1024, -1024, -1024, 0);
    add_word(1023, 1023, -1024, -1024, 0);
    add_word(650, 650, -650, -650, 0);
    add_word(651, 651, -651, -651, 0);

    // zero threshold and hold: every gesture acts on its first tick
    add_drain();
    add_cfg(REG_UNUSED_LO, 32767);
    add_cfg(REG_UNUSED_HI, 0);
    add_cfg(REG_THRESHOLD, 0);
    add_cfg(REG_HOLD, 0);
    for (int i = 0; i < NUM_GEST; i++) add_gesture_tick(i, 0, -1);
    add_gesture_tick(GEST_READ, 1 << KEY_C, -1);
    add_word(0, 0, 0, 0, 0);

    // top threshold: only a full negative swing counts as deflected
    add_drain();
    add_cfg(REG_THRESHOLD, 1023);
    add_word(1023, 1023, -1024, -1024, 0);
    add_word(-1024, -1024, 1023, -1024, 0);

    // hold one gesture across the hold limit
    add_drain();
    add_cfg(REG_THRESHOLD, 100);
    add_cfg(REG_HOLD, 5);
    plan_gap_pct   = 0;
    plan_stall_pct = 2;
    for (int i = 0; i < 10; i++) add_gesture_tick(1, 0, -1);

    for (int ph = 0; ph < 12; ph++) begin
      add_drain();
      case (ph)
        0:       thr = 0;
        1:       thr = 1023;
        5:       thr = $urandom_range(60);
        default: thr = $urandom_range(900, 100);
      endcase
      case (ph)
        2:       hold = 0;
        3:       hold = 32766;
        7:       hold = $urandom_range(25, 10);
        default: hold = $urandom_range(5);
      endcase
      add_cfg(REG_THRESHOLD, thr);
      add_cfg(REG_HOLD, hold);
      if (ph >= 10) begin
        plan_gap_pct   = 0;
        plan_stall_pct = 0;
      end else begin
        plan_gap_pct   = pick_pct();
        plan_stall_pct = pick_pct();
      end
      n      = 0;
      paused = 1'b0;
      while (n < 100) begin
        case ($urandom_range(19))
          0, 1, 2: begin
            add_word($urandom_range(2047), $urandom_range(2047), $urandom_range(2047),
                     $urandom_range(2047), $urandom_range(31));
            n++;
          end
          default: begin
            g       = $urandom_range(NUM_GEST - 1);
            len     = $urandom_range((plan_hold + 4 > 40) ? 40 : plan_hold + 4, 1);
            bent_at = ($urandom_range(4) == 0) ? $urandom_range(len - 1) : -1;
            for (int k = 0; k < len; k++)
              add_gesture_tick(g, rand_keys(), (k == bent_at) ? $urandom_range(3) : -1);
            n += len;
          end
        endcase
        if (ph == 6 && n >= 50 && !paused) begin
          add_drain();
          paused = 1'b1;
        end
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (op_q.size() != 0 || in_if.valid || modes_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (modes_due.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
